// File: sv/weighted_table_sampler_defines.svh
// Assertion macros shared by the weighted table sampler checker.
// Depends on nothing; the using module supplies clk and rst.
`ifndef WEIGHTED_TABLE_SAMPLER_DEFINES_SVH
`define WEIGHTED_TABLE_SAMPLER_DEFINES_SVH

// same-cycle implication
`define WTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/wts_pkg.sv
// Types and codes for the weighted table sampler.
// Used by the top level and its checker; depends on nothing.
package wts_pkg;

  localparam int KEY_W = 31;
  localparam int WGT_W = 16;
  localparam int RND_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DRAW   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] entry_key;
    logic [WGT_W-1:0] entry_weight;
    logic [RND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] picked_key;
    logic [1:0]       status;
  } rsp_t;

endpackage

// File: sv/weighted_table_sampler.sv
// Weighted table sampler: keeps (key, running sum) entries in one memory
// and draws keys by a bit-serial modulo followed by a linear table scan.
// Depends on wts_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------
//  req     | in        | req_valid/req_stall| wts_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall| wts_pkg::rsp_t
//
// Clear, append, unused opcode and a draw on an empty table answer in the
// cycle after acceptance. Draw: accept cycle, restoring modulo (one random
// bit per cycle), table scan with one memory read a cycle, then result load.
// Reset clears the entry count and total; the table needs no clearing pass.
// req_stall is high while an item is in work or a result waits under rsp_stall.
module weighted_table_sampler #(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wts_pkg::rsp_t rsp
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int KEY_W  = wts_pkg::KEY_W;
  localparam int WGT_W  = wts_pkg::WGT_W;
  localparam int RND_W  = wts_pkg::RND_W;
  localparam int BIT_W  = $clog2(RND_W);
  localparam int MASK_B = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
  localparam logic [WGT_W-1:0] WMASK = WGT_W'((33'd1 << MASK_B) - 33'd1);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    SEARCH,
    DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
  } entry_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  rem;
  logic [RND_W-1:0]  rnd_sh;
  logic [BIT_W-1:0]  bit_cnt;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_pend;
  logic [KEY_W-1:0]  hit_key;

  entry_t            tbl [MAX_ENTRIES];
  entry_t            rd_data;
  logic              wr_en;
  entry_t            wr_data;

  logic              accept;
  logic              slot_free;
  logic [WGT_W-1:0]  wgt_masked;
  logic [SUM_W-1:0]  wgt;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    rem_sub;
  logic              append_ok;
  logic              draw_go;
  logic              rsp_load;

  assign req_stall  = (state != IDLE) || (rsp_valid && rsp_stall);
  assign accept     = req_valid && !req_stall;
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign wgt_masked = req.entry_weight & WMASK;
  assign wgt        = SUM_W'(wgt_masked);
  assign rem_sh     = {rem, rnd_sh[RND_W-1]};
  assign rem_sub    = rem_sh - {1'b0, total};

  assign draw_go  = (req.opcode == wts_pkg::OP_DRAW) && (count != '0) && (total != '0);
  assign rsp_load = ((state == IDLE) && accept && !draw_go) ||
                    ((state == DONE) && slot_free);

  assign append_ok = accept && (req.opcode == wts_pkg::OP_APPEND) &&
                     (req.entry_key != '0) && (wgt_masked != '0) &&
                     (count != CNT_W'(MAX_ENTRIES));
  assign wr_en       = append_ok;
  assign wr_data.key = req.entry_key;
  assign wr_data.sum = total + wgt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[count[IDX_W-1:0]] <= wr_data;
    end
    rd_data <= tbl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      rd_addr   <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            case (req.opcode)
              wts_pkg::OP_CLEAR: begin
                count     <= '0;
                total     <= '0;
                rsp       <= '{picked_key: '0, status: wts_pkg::ST_OK};
                rsp_valid <= 1'b1;
              end
              wts_pkg::OP_APPEND: begin
                rsp.picked_key <= '0;
                rsp_valid      <= 1'b1;
                if ((req.entry_key == '0) || (wgt_masked == '0)) begin
                  rsp.status <= wts_pkg::ST_INVALID;
                end else if (count == CNT_W'(MAX_ENTRIES)) begin
                  rsp.status <= wts_pkg::ST_FULL;
                end else begin
                  rsp.status <= wts_pkg::ST_OK;
                  total      <= wr_data.sum;
                  count      <= count + CNT_W'(1);
                end
              end
              wts_pkg::OP_DRAW: begin
                if ((count == '0) || (total == '0)) begin
                  rsp       <= '{picked_key: '0, status: wts_pkg::ST_EMPTY};
                  rsp_valid <= 1'b1;
                end else begin
                  rem     <= '0;
                  rnd_sh  <= req.random_value;
                  bit_cnt <= '1;
                  state   <= DIVIDE;
                end
              end
              default: begin
                rsp       <= '{picked_key: '0, status: wts_pkg::ST_OK};
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        DIVIDE: begin
          rnd_sh <= {rnd_sh[RND_W-2:0], 1'b0};
          if (!rem_sub[SUM_W]) begin
            rem <= rem_sub[SUM_W-1:0];
          end else begin
            rem <= rem_sh[SUM_W-1:0];
          end
          bit_cnt <= bit_cnt - BIT_W'(1);
          if (bit_cnt == '0) begin
            rd_addr <= '0;
            rd_pend <= 1'b0;
            state   <= SEARCH;
          end
        end
        SEARCH: begin
          rd_addr <= rd_addr + IDX_W'(1);
          if (rd_pend && (rem < rd_data.sum)) begin
            hit_key <= rd_data.key;
            rd_pend <= 1'b0;
            state   <= DONE;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        DONE: begin
          if (slot_free) begin
            rsp       <= '{picked_key: hit_key, status: wts_pkg::ST_OK};
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/wts_checker.sv
// Port-level checks for the weighted table sampler, bound to its top level.
// Depends on wts_pkg and weighted_table_sampler_defines.svh.
`include "weighted_table_sampler_defines.svh"

module wts_props (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input wts_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input wts_pkg::rsp_t rsp
);

  logic req_acc;
  logic quick_op;
  logic key_zero;
  logic rsp_wait;

  assign req_acc  = req_valid && !req_stall;
  assign quick_op = (req.opcode != wts_pkg::OP_DRAW);
  assign key_zero = (rsp.picked_key == '0);
  assign rsp_wait = rsp_valid && rsp_stall;

  `WTS_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "rsp item changed in stall")

  `WTS_ASSERT_NEXT(a_quick_rsp, req_acc && quick_op, rsp_valid && key_zero, "no zero-key rsp")

  `WTS_ASSERT_NOW(a_key_ok, rsp_valid && !key_zero, rsp.status == wts_pkg::ST_OK, "bad status")

  `WTS_ASSERT_NOW(a_stall_busy, rsp_wait, req_stall, "req taken while rsp item waits")

endmodule

bind weighted_table_sampler wts_props u_wts_props (.*);
